>>> src/bocbw_pkg.sv
// ----------------------------------------------------------------------------
// bocbw_pkg: shared definitions for the bulk-only wrapper engine
// Constants, signature bytes, result structs and the status-byte selector.
// ----------------------------------------------------------------------------
`default_nettype none

package bocbw_pkg;

    // Wrapper geometry.
    localparam int CBW_LENGTH = 31;
    localparam int CDB_BYTES  = 16;
    localparam int CSW_BYTES  = 13;
    localparam int COUNT_MAX  = 32;

    localparam logic [7:0] LUN_MASK = 8'h0F;

    // Byte positions inside the command wrapper.
    localparam logic [5:0] POS_TAG    = 6'd4;
    localparam logic [5:0] POS_LENGTH = 6'd8;
    localparam logic [5:0] POS_FLAGS  = 6'd12;
    localparam logic [5:0] POS_LUN    = 6'd13;
    localparam logic [5:0] POS_CDB    = 6'd15;

    // Signature of a command wrapper, one byte per position.
    function automatic logic [7:0] cbw_sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h55;
            2'd1:    b = 8'h53;
            2'd2:    b = 8'h42;
            2'd3:    b = 8'h43;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Byte of the status wrapper at a given position.
    function automatic logic [7:0] csw_byte(input logic [3:0] idx,
                                            input logic [31:0] tag,
                                            input logic [31:0] residue,
                                            input logic [7:0] status);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h55;
            4'd1:    b = 8'h53;
            4'd2:    b = 8'h42;
            4'd3:    b = 8'h53;
            4'd4:    b = tag[7:0];
            4'd5:    b = tag[15:8];
            4'd6:    b = tag[23:16];
            4'd7:    b = tag[31:24];
            4'd8:    b = residue[7:0];
            4'd9:    b = residue[15:8];
            4'd10:   b = residue[23:16];
            4'd11:   b = residue[31:24];
            4'd12:   b = status;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Report from the command parser, valid on the last packet byte.
    typedef struct packed {
        logic        valid;
        logic        good;
        logic [31:0] tag;
        logic [31:0] length;
        logic [7:0]  flags;
        logic [3:0]  lun;
        logic [63:0] cdb_low;
        logic [63:0] cdb_high;
    } cbw_report_t;

    // One result item as held in the output register.
    typedef struct packed {
        logic        kind;
        logic        cbw_good;
        logic        stall_res;
        logic [31:0] tag;
        logic [31:0] transfer_length;
        logic [7:0]  direction;
        logic [3:0]  lun;
        logic [63:0] cdb_low;
        logic [63:0] cdb_high;
        logic [7:0]  tx_byte;
        logic        tx_last;
    } res_item_t;

endpackage

`default_nettype wire

>>> src/bocbw_in_if.sv
// ----------------------------------------------------------------------------
// bocbw_in_if: input channel of the wrapper engine
// Valid/ready channel carrying packet bytes and send-status requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface bocbw_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  data_byte;
    logic        packet_last;
    logic [7:0]  csw_status;
    logic [31:0] csw_residue;
    logic        csw_abort;

    modport source (
        output valid, mode, data_byte, packet_last, csw_status, csw_residue, csw_abort,
        input  ready
    );

    modport sink (
        input  valid, mode, data_byte, packet_last, csw_status, csw_residue, csw_abort,
        output ready
    );
endinterface

`default_nettype wire

>>> src/bocbw_out_if.sv
// ----------------------------------------------------------------------------
// bocbw_out_if: result channel of the wrapper engine
// Valid/ready channel carrying wrapper reports and status wrapper bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bocbw_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        cbw_good;
    logic        stall_res;
    logic [31:0] tag;
    logic [31:0] transfer_length;
    logic [7:0]  direction;
    logic [3:0]  lun;
    logic [63:0] cdb_low;
    logic [63:0] cdb_high;
    logic [7:0]  tx_byte;
    logic        tx_last;

    modport source (
        output valid, kind, cbw_good, stall_res, tag, transfer_length, direction, lun,
               cdb_low, cdb_high, tx_byte, tx_last,
        input  ready
    );

    modport sink (
        input  valid, kind, cbw_good, stall_res, tag, transfer_length, direction, lun,
               cdb_low, cdb_high, tx_byte, tx_last,
        output ready
    );
endinterface

`default_nettype wire

>>> src/bocbw_parse.sv
// ----------------------------------------------------------------------------
// bocbw_parse: command wrapper parser
// Counts packet bytes, checks the signature, captures the wrapper fields and
// reports on the last byte. Keeps the tag of the last good wrapper.
// ----------------------------------------------------------------------------
`default_nettype none

module bocbw_parse (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     take,
    input  wire  [7:0]              data_byte,
    input  wire                     packet_last,
    output bocbw_pkg::cbw_report_t  report,
    output logic [31:0]             saved_tag
);

    logic [5:0]  count_reg;
    logic [5:0]  count_next;
    logic        sig_ok_reg;
    logic        sig_ok_next;
    logic [31:0] tag_cap_reg;
    logic [31:0] tag_cap_next;
    logic [31:0] length_reg;
    logic [31:0] length_next;
    logic [7:0]  flags_reg;
    logic [7:0]  flags_next;
    logic [3:0]  lun_reg;
    logic [3:0]  lun_next;
    logic [31:0] saved_tag_reg;
    logic [7:0]  cmd_reg  [bocbw_pkg::CDB_BYTES];
    logic [7:0]  cmd_next [bocbw_pkg::CDB_BYTES];
    logic        cmd_we;
    logic [3:0]  cmd_idx;
    logic [5:0]  pos;
    logic        good;

    assign pos     = count_reg;
    // Positions 15..30 map onto command bytes 0..15.
    assign cmd_idx = pos[3:0] + 4'd1;
    assign cmd_we  = take && (pos >= bocbw_pkg::POS_CDB)
                     && (pos < 6'(bocbw_pkg::CBW_LENGTH));

    // Field capture and signature check for the current byte.
    always_comb
    begin
        sig_ok_next  = sig_ok_reg;
        tag_cap_next = (pos == 6'd0) ? 32'd0 : tag_cap_reg;
        length_next  = (pos == 6'd0) ? 32'd0 : length_reg;
        flags_next   = (pos == 6'd0) ? 8'd0 : flags_reg;
        lun_next     = (pos == 6'd0) ? 4'd0 : lun_reg;

        if (pos < bocbw_pkg::POS_TAG)
        begin
            if (data_byte != bocbw_pkg::cbw_sig_byte(pos[1:0]))
            begin
                sig_ok_next = 1'b0;
            end
        end
        else if (pos < bocbw_pkg::POS_LENGTH)
        begin
            tag_cap_next[8*pos[1:0] +: 8] = data_byte;
        end
        else if (pos < bocbw_pkg::POS_FLAGS)
        begin
            length_next[8*pos[1:0] +: 8] = data_byte;
        end
        else if (pos == bocbw_pkg::POS_FLAGS)
        begin
            flags_next = data_byte;
        end
        else if (pos == bocbw_pkg::POS_LUN)
        begin
            lun_next = 4'(data_byte & bocbw_pkg::LUN_MASK);
        end

        for (int i = 0; i < bocbw_pkg::CDB_BYTES; i++)
        begin
            cmd_next[i] = (cmd_we && (cmd_idx == 4'(i))) ? data_byte : cmd_reg[i];
        end

        // Saturating byte counter.
        count_next = (count_reg < 6'(bocbw_pkg::COUNT_MAX)) ? count_reg + 6'd1 : count_reg;
    end

    assign good = sig_ok_next && (count_next == 6'(bocbw_pkg::CBW_LENGTH));

    // Report built from the values after this byte.
    always_comb
    begin
        report          = '0;
        report.valid    = take && packet_last;
        report.good     = good;
        if (good)
        begin
            report.tag    = tag_cap_next;
            report.length = length_next;
            report.flags  = flags_next;
            report.lun    = lun_next;
            for (int i = 0; i < 8; i++)
            begin
                report.cdb_low[8*i +: 8]  = cmd_next[i];
                report.cdb_high[8*i +: 8] = cmd_next[i + 8];
            end
        end
    end

    // Control state and captures.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sig_ok_reg    <= 1'b1;
            tag_cap_reg   <= '0;
            length_reg    <= '0;
            flags_reg     <= '0;
            lun_reg       <= '0;
            saved_tag_reg <= '0;
        end
        else if (take)
        begin
            tag_cap_reg <= tag_cap_next;
            length_reg  <= length_next;
            flags_reg   <= flags_next;
            lun_reg     <= lun_next;
            if (packet_last)
            begin
                count_reg  <= '0;
                sig_ok_reg <= 1'b1;
                if (good)
                begin
                    saved_tag_reg <= tag_cap_next;
                end
            end
            else
            begin
                count_reg  <= count_next;
                sig_ok_reg <= sig_ok_next;
            end
        end
    end

    // Command byte store, written once per position.
    always_ff @(posedge clk)
    begin
        if (cmd_we)
        begin
            cmd_reg[cmd_idx] <= data_byte;
        end
    end

    assign saved_tag = saved_tag_reg;

endmodule

`default_nettype wire

>>> src/bulk_only_cbw_parse_csw_build.sv
// ----------------------------------------------------------------------------
// bulk_only_cbw_parse_csw_build: bulk-only command and status wrapper engine
// Parses command wrappers byte by byte and builds the 13-byte status wrapper.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch carries requests. With mode 0 a request is one bulk-out packet
//   byte; the byte marked packet_last yields one report on rsp_ch telling
//   whether the packet was a good 31-byte command wrapper, with its fields,
//   or a stall request for a bad one. With mode 1 a request asks for the
//   status wrapper: if a good wrapper is pending and abort is clear, 13
//   status bytes follow on rsp_ch, the last one marked by tx_last.
//   Packet bytes are taken one per cycle while cmd_ch.ready is high; a
//   report appears in the output register in the cycle after its last byte
//   is accepted. A status request occupies the block: cmd_ch.ready stays
//   low while the byte counter of the status serializer walks the wrapper.
//   The single output register lets a new request in while a result waits,
//   as long as rsp_ch.ready takes it in the same cycle; when the receiver
//   stalls, the result holds and cmd_ch.ready drops.
//   Reset clears the byte counter, pending flag, captures and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bulk_only_cbw_parse_csw_build (
    input  wire        clk,
    input  wire        rst_n,
    bocbw_in_if.sink   cmd_ch,
    bocbw_out_if.source rsp_ch
);

    bocbw_pkg::cbw_report_t report;
    bocbw_pkg::res_item_t   out_reg;
    bocbw_pkg::res_item_t   out_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        accept;
    logic        take_byte;
    logic        start_csw;
    logic        pending_reg;
    logic        pending_next;
    logic        burst_reg;
    logic        burst_next;
    logic [3:0]  idx_reg;
    logic [3:0]  idx_next;
    logic [31:0] b_tag_reg;
    logic [31:0] b_res_reg;
    logic [7:0]  b_status_reg;
    logic [31:0] saved_tag;

    assign out_free     = !out_valid_reg || rsp_ch.ready;
    assign cmd_ch.ready = !burst_reg && out_free;
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign take_byte    = accept && !cmd_ch.mode;
    assign start_csw    = accept && cmd_ch.mode && !cmd_ch.csw_abort && pending_reg;

    bocbw_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take_byte),
        .data_byte   (cmd_ch.data_byte),
        .packet_last (cmd_ch.packet_last),
        .report      (report),
        .saved_tag   (saved_tag)
    );

    // Pending status: armed by a good wrapper, dropped by any status request.
    always_comb
    begin
        pending_next = pending_reg;
        if (accept && cmd_ch.mode)
        begin
            pending_next = 1'b0;
        end
        else if (report.valid && report.good)
        begin
            pending_next = 1'b1;
        end
    end

    // Output register load and status serializer.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        burst_next     = burst_reg;
        idx_next       = idx_reg;
        if (out_free)
        begin
            out_valid_next = 1'b0;
            if (burst_reg)
            begin
                out_next         = '0;
                out_next.kind    = 1'b1;
                out_next.tx_byte = bocbw_pkg::csw_byte(idx_reg, b_tag_reg, b_res_reg,
                                                       b_status_reg);
                out_next.tx_last = (idx_reg == 4'(bocbw_pkg::CSW_BYTES - 1));
                out_valid_next   = 1'b1;
                idx_next         = idx_reg + 4'd1;
                burst_next       = !out_next.tx_last;
            end
            else if (report.valid)
            begin
                out_next                 = '0;
                out_next.cbw_good        = report.good;
                out_next.stall_res       = !report.good;
                out_next.tag             = report.tag;
                out_next.transfer_length = report.length;
                out_next.direction       = report.flags;
                out_next.lun             = report.lun;
                out_next.cdb_low         = report.cdb_low;
                out_next.cdb_high        = report.cdb_high;
                out_valid_next           = 1'b1;
            end
            else if (start_csw)
            begin
                out_next         = '0;
                out_next.kind    = 1'b1;
                out_next.tx_byte = bocbw_pkg::csw_byte(4'd0, saved_tag, cmd_ch.csw_residue,
                                                       cmd_ch.csw_status);
                out_valid_next   = 1'b1;
                idx_next         = 4'd1;
                burst_next       = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
            burst_reg     <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pending_reg   <= pending_next;
            burst_reg     <= burst_next;
            idx_reg       <= idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (start_csw)
        begin
            b_tag_reg    <= saved_tag;
            b_res_reg    <= cmd_ch.csw_residue;
            b_status_reg <= cmd_ch.csw_status;
        end
    end

    assign rsp_ch.valid           = out_valid_reg;
    assign rsp_ch.kind            = out_reg.kind;
    assign rsp_ch.cbw_good        = out_reg.cbw_good;
    assign rsp_ch.stall_res       = out_reg.stall_res;
    assign rsp_ch.tag             = out_reg.tag;
    assign rsp_ch.transfer_length = out_reg.transfer_length;
    assign rsp_ch.direction       = out_reg.direction;
    assign rsp_ch.lun             = out_reg.lun;
    assign rsp_ch.cdb_low         = out_reg.cdb_low;
    assign rsp_ch.cdb_high        = out_reg.cdb_high;
    assign rsp_ch.tx_byte         = out_reg.tx_byte;
    assign rsp_ch.tx_last         = out_reg.tx_last;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the bulk-only command and status wrapper engine
// Sends command packet bytes and send-status requests, predicts every report
// and status wrapper byte in step with accepted requests, and checks each
// result against the oldest prediction while both sides idle at random.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 6;
    localparam int          QUIET_LIMIT  = 3000;
    localparam int          DRAIN_CYCLES = 30;
    localparam int          LONG_HOLD    = 300;
    localparam int          MAX_REPORTS  = 10;
    localparam int          RANDOM_ITEMS = 90;
    localparam logic [31:0] CBW_SIG      = 32'h4342_5355;  // 55 53 42 43, first byte lowest
    localparam logic [31:0] CSW_SIG      = 32'h5342_5355;  // 55 53 42 53, first byte lowest
    localparam bit          MODE_BYTE    = 1'b0;
    localparam bit          MODE_STATUS  = 1'b1;

    typedef struct {
        bit        mode;
        bit [7:0]  data;
        bit        last;
        bit [7:0]  status;
        bit [31:0] residue;
        bit        abort_req;
    } engine_req_t;

    logic clk;
    logic rst_n;

    bocbw_in_if  cmd_if();
    bocbw_out_if rsp_if();

    bulk_only_cbw_parse_csw_build dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_if),
        .rsp_ch (rsp_if)
    );

    // Requests waiting to be sent and results the engine still owes.
    engine_req_t           req_backlog[$];
    bocbw_pkg::res_item_t  due_rsp_q[$];

    // Shadow copy of the engine state.
    logic [5:0]  pkt_len;
    logic        sig_match;
    logic [31:0] last_tag;
    logic [31:0] tag_work;
    logic [31:0] xfer_len;
    logic [7:0]  flags_byte;
    logic [3:0]  lun_nib;
    logic [7:0]  cdb_mem [bocbw_pkg::CDB_BYTES];
    logic        csw_armed;

    int          src_idle_pct;
    int          snk_idle_pct;
    bit          hold_trigger;
    bit          hold_served;
    int          hold_left;
    bit          req_fire;
    int          error_count;
    int          quiet_cycles;
    int          queued_items;

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Advance the shadow engine by one accepted request and queue what it owes.
    function automatic void cbw_csw_step(engine_req_t r);
        bocbw_pkg::res_item_t item;
        bit                   good;
        int                   p;
        logic [7:0]           wrapper [bocbw_pkg::CSW_BYTES];
        if (r.mode == MODE_BYTE)
        begin
            p = pkt_len;
            if (p == 0)
            begin
                tag_work   = '0;
                xfer_len   = '0;
                flags_byte = '0;
                lun_nib    = '0;
            end
            // Capture the field this byte position belongs to.
            if (p < bocbw_pkg::CBW_LENGTH)
            begin
                if (p < bocbw_pkg::POS_TAG)
                begin
                    if (r.data != CBW_SIG[8 * p +: 8])
                        sig_match = 1'b0;
                end
                else if (p < bocbw_pkg::POS_LENGTH)
                    tag_work[8 * (p - bocbw_pkg::POS_TAG) +: 8] = r.data;
                else if (p < bocbw_pkg::POS_FLAGS)
                    xfer_len[8 * (p - bocbw_pkg::POS_LENGTH) +: 8] = r.data;
                else if (p == bocbw_pkg::POS_FLAGS)
                    flags_byte = r.data;
                else if (p == bocbw_pkg::POS_LUN)
                    lun_nib = 4'(r.data & bocbw_pkg::LUN_MASK);
                else if (p >= bocbw_pkg::POS_CDB)
                    cdb_mem[p - bocbw_pkg::POS_CDB] = r.data;
            end
            if (pkt_len < bocbw_pkg::COUNT_MAX)
                pkt_len = pkt_len + 6'd1;
            if (!r.last)
                return;
            // End of packet: one report, good or stall.
            good = sig_match && (pkt_len == bocbw_pkg::CBW_LENGTH);
            item = '0;
            item.cbw_good  = good;
            item.stall_res = !good;
            if (good)
            begin
                last_tag  = tag_work;
                csw_armed = 1'b1;
                item.tag             = last_tag;
                item.transfer_length = xfer_len;
                item.direction       = flags_byte;
                item.lun             = lun_nib;
                for (int k = 0; k < 8; k++)
                begin
                    item.cdb_low[8 * k +: 8]  = cdb_mem[k];
                    item.cdb_high[8 * k +: 8] = cdb_mem[8 + k];
                end
            end
            due_rsp_q.push_back(item);
            pkt_len   = '0;
            sig_match = 1'b1;
            return;
        end
        // Send-status request: abort clears, otherwise emit only when armed.
        if (r.abort_req)
        begin
            csw_armed = 1'b0;
            return;
        end
        if (!csw_armed)
            return;
        for (int k = 0; k < 4; k++)
        begin
            wrapper[k]     = CSW_SIG[8 * k +: 8];
            wrapper[4 + k] = last_tag[8 * k +: 8];
            wrapper[8 + k] = r.residue[8 * k +: 8];
        end
        wrapper[12] = r.status;
        for (int k = 0; k < bocbw_pkg::CSW_BYTES; k++)
        begin
            item = '0;
            item.kind    = 1'b1;
            item.tx_byte = wrapper[k];
            item.tx_last = (k == bocbw_pkg::CSW_BYTES - 1);
            due_rsp_q.push_back(item);
        end
        csw_armed = 1'b0;
    endfunction

    function automatic string fmt_rsp(bocbw_pkg::res_item_t r);
        return $sformatf({"kind=%0b good=%0b stall=%0b tag=%h len=%h dir=%h lun=%h ",
                          "cdb=%h_%h tx=%h last=%0b"},
                         r.kind, r.cbw_good, r.stall_res, r.tag, r.transfer_length,
                         r.direction, r.lun, r.cdb_high, r.cdb_low, r.tx_byte, r.tx_last);
    endfunction

    function automatic void note_error(string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $time, what);
    endfunction

    // Request builders.
    task automatic queue_req(bit mode, bit [7:0] data, bit last, bit [7:0] status,
                             bit [31:0] residue, bit abort_req);
        engine_req_t r;
        r.mode      = mode;
        r.data      = data;
        r.last      = last;
        r.status    = status;
        r.residue   = residue;
        r.abort_req = abort_req;
        req_backlog.push_back(r);
        queued_items++;
    endtask

    // One packet of len bytes led by the wrapper signature; fill < 0 means
    // random content, otherwise every byte after the signature is fill.
    task automatic queue_packet(int len, int fill, bit sig_flip);
        bit [7:0] b;
        int       flip_pos;
        flip_pos = $urandom_range(0, 3);
        for (int p = 0; p < len; p++)
        begin
            if (p < 4)
            begin
                b = CBW_SIG[8 * p +: 8];
                if (sig_flip && p == flip_pos)
                    b[$urandom_range(0, 7)] ^= 1'b1;
            end
            else if (fill < 0)
                b = 8'($urandom);
            else
                b = 8'(fill);
            queue_req(MODE_BYTE, b, p == len - 1, 8'($urandom), $urandom,
                      1'($urandom));
        end
    endtask

    task automatic queue_status(bit [7:0] status, bit [31:0] residue, bit abort_req);
        queue_req(MODE_STATUS, 8'($urandom), 1'($urandom), status, residue, abort_req);
    endtask

    // Random traffic, mostly good wrappers followed by a status request.
    task automatic queue_random(int count);
        int start;
        int sel;
        start = queued_items;
        while (queued_items - start < count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                queue_packet(bocbw_pkg::CBW_LENGTH, -1, 1'b0);
                if ($urandom_range(0, 99) < 85)
                    queue_status(8'($urandom), $urandom, $urandom_range(0, 99) < 15);
            end
            else if (sel < 65)
                queue_packet($urandom_range(1, bocbw_pkg::CBW_LENGTH - 1), -1, 1'b0);
            else if (sel < 73)
                queue_packet($urandom_range(bocbw_pkg::COUNT_MAX, 40), -1, 1'b0);
            else if (sel < 83)
                queue_packet(bocbw_pkg::CBW_LENGTH, -1, 1'b1);
            else if (sel < 93)
                queue_status(8'($urandom), $urandom, $urandom_range(0, 99) < 20);
            else
            begin
                // Loose bytes with random end marks.
                repeat ($urandom_range(1, 8))
                    queue_req(MODE_BYTE, 8'($urandom), 1'($urandom), 8'($urandom),
                              $urandom, 1'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || cmd_if.valid || due_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Request driver: new values at the falling edge.
    always @(negedge clk)
    begin
        engine_req_t r;
        if (rst_n && (!cmd_if.valid || req_fire))
        begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                r = req_backlog.pop_front();
                cmd_if.mode        <= r.mode;
                cmd_if.data_byte   <= r.data;
                cmd_if.packet_last <= r.last;
                cmd_if.csw_status  <= r.status;
                cmd_if.csw_residue <= r.residue;
                cmd_if.csw_abort   <= r.abort_req;
                cmd_if.valid       <= 1'b1;
            end
            else
                cmd_if.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_trigger && !hold_served)
        begin
            rsp_if.ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_served <= 1'b1;
        end
        else
            rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Handshake monitor, result check and watchdog at the rising edge.
    always @(posedge clk)
    begin
        engine_req_t          r;
        bocbw_pkg::res_item_t got;
        bocbw_pkg::res_item_t want;
        bit                   rsp_fire;
        req_fire = rst_n && cmd_if.valid && cmd_if.ready;
        rsp_fire = rst_n && rsp_if.valid && rsp_if.ready;
        if (req_fire)
        begin
            r.mode      = cmd_if.mode;
            r.data      = cmd_if.data_byte;
            r.last      = cmd_if.packet_last;
            r.status    = cmd_if.csw_status;
            r.residue   = cmd_if.csw_residue;
            r.abort_req = cmd_if.csw_abort;
            cbw_csw_step(r);
        end
        if (rsp_fire)
        begin
            got.kind            = rsp_if.kind;
            got.cbw_good        = rsp_if.cbw_good;
            got.stall_res       = rsp_if.stall_res;
            got.tag             = rsp_if.tag;
            got.transfer_length = rsp_if.transfer_length;
            got.direction       = rsp_if.direction;
            got.lun             = rsp_if.lun;
            got.cdb_low         = rsp_if.cdb_low;
            got.cdb_high        = rsp_if.cdb_high;
            got.tx_byte         = rsp_if.tx_byte;
            got.tx_last         = rsp_if.tx_last;
            if (due_rsp_q.size() == 0)
                note_error({"unexpected result: ", fmt_rsp(got)});
            else
            begin
                want = due_rsp_q.pop_front();
                if (got !== want)
                    note_error({"mismatch\n  expected ", fmt_rsp(want),
                                "\n  actual   ", fmt_rsp(got)});
            end
        end
        // Watchdog on cycles without any handshake.
        if (req_fire || rsp_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("tb_top failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        cmd_if.valid       = 1'b0;
        cmd_if.mode        = MODE_BYTE;
        cmd_if.data_byte   = '0;
        cmd_if.packet_last = 1'b0;
        cmd_if.csw_status  = '0;
        cmd_if.csw_residue = '0;
        cmd_if.csw_abort   = 1'b0;
        rsp_if.ready       = 1'b0;
        req_fire     = 1'b0;
        hold_trigger = 1'b0;
        hold_served  = 1'b0;
        hold_left    = 0;
        error_count  = 0;
        quiet_cycles = 0;
        queued_items = 0;
        src_idle_pct = 9;
        snk_idle_pct = 67;
        pkt_len   = '0;
        sig_match = 1'b1;
        last_tag  = '0;
        tag_work  = '0;
        xfer_len  = '0;
        flags_byte = '0;
        lun_nib   = '0;
        csw_armed = 1'b0;
        for (int k = 0; k < bocbw_pkg::CDB_BYTES; k++)
            cdb_mem[k] = '0;

        @(posedge rst_n);

        // Directed cases first.
        // Status request with nothing pending gives no result.
        queue_status(8'hFF, 32'hFFFF_FFFF, 1'b0);
        // A one-byte packet is a short, bad wrapper.
        queue_req(MODE_BYTE, 8'hFF, 1'b1, 8'h00, 32'h0, 1'b1);
        // Good wrapper with every field at its maximum, then an abort.
        queue_packet(bocbw_pkg::CBW_LENGTH, 8'hFF, 1'b0);
        queue_status(8'h00, 32'h0, 1'b1);
        queue_status(8'h5A, $urandom, 1'b0);
        // One byte too long, then two good wrappers in a row.
        queue_packet(bocbw_pkg::COUNT_MAX, 8'h00, 1'b0);
        queue_packet(bocbw_pkg::CBW_LENGTH, 8'h00, 1'b0);
        queue_packet(bocbw_pkg::CBW_LENGTH, -1, 1'b0);
        queue_status(8'hFF, 32'hFFFF_FFFF, 1'b0);
        queue_status(8'h00, 32'h0, 1'b0);
        // Broken signature, one byte short, and well past saturation.
        queue_packet(bocbw_pkg::CBW_LENGTH, -1, 1'b1);
        queue_packet(bocbw_pkg::CBW_LENGTH - 1, -1, 1'b0);
        queue_packet(40, -1, 1'b0);

        // Random phase one: sender mostly busy, receiver often stalls.
        queue_random(RANDOM_ITEMS / 3);
        wait_drained();

        // Random phase two: the other way round.
        src_idle_pct = 67;
        snk_idle_pct = 9;
        queue_random(RANDOM_ITEMS / 3);
        wait_drained();

        // Random phase three: no idling, with one long receiver hold-off.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_random(RANDOM_ITEMS / 3);
        hold_trigger = 1'b1;
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_rsp_q.size() != 0)
            note_error($sformatf("%0d expected results never arrived", due_rsp_q.size()));
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
